/* src/xbf_pkg.sv */
// Package for the XMODEM block framer: beat types, protocol symbols and the CRC polynomial.
// It depends on nothing else and is compiled first.
`timescale 1ns / 1ps

package xbf_pkg;

  localparam int BLOCK_BYTES = 128;

  localparam logic [7:0]  SYM_SOH  = 8'h01;
  localparam logic [7:0]  SYM_EOT  = 8'h04;
  localparam logic [7:0]  SYM_PAD  = 8'h1A;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [6:0] repeat_count;
    logic       last_result;
  } out_item_t;

endpackage

/* src/xmodem_block_framer_top.sv */
// XMODEM sender block framer: header, data pass-through, padding, checksum or CRC-16 trailer.
// It depends on xbf_pkg for beat types and symbols.
// It takes one byte at a time and reopens its input once that byte and any trailer are out.
// The trailer waits for the accumulator, which absorbs one bit per cycle in CRC mode.
// End of file sends up to 127 pad bytes in one repeated beat, at most 5 output beats in all.
// Synchronous reset: block number 1, empty block, checksum mode, no result pending.
`timescale 1ns / 1ps

module xmodem_block_framer_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic              item_valid,
  output logic              item_ready,
  input  xbf_pkg::in_item_t item,
  output logic              result_valid,
  input  logic              result_ready,
  output xbf_pkg::out_item_t result
);
  import xbf_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_HDR_SOH = 11'b000_0000_0010,
    ST_HDR_NUM = 11'b000_0000_0100,
    ST_HDR_CPL = 11'b000_0000_1000,
    ST_ABSORB  = 11'b000_0001_0000,
    ST_DATA    = 11'b000_0010_0000,
    ST_PAD     = 11'b000_0100_0000,
    ST_TRL_HI  = 11'b000_1000_0000,
    ST_TRL_LO  = 11'b001_0000_0000,
    ST_EOT_A   = 11'b010_0000_0000,
    ST_EOT_B   = 11'b100_0000_0000
  } state_t;

  state_t      state;
  state_t      state_next;
  state_t      trl_state;
  logic        crc_mode;
  logic [7:0]  block_number;
  logic [7:0]  fill_count;
  logic [15:0] check_acc;
  logic [7:0]  shift_byte;
  logic [2:0]  bit_cnt;
  logic [6:0]  pad_left;
  logic        is_eof;
  logic [7:0]  cur_byte;
  logic        accept;
  logic        can_load;
  logic        emit;
  out_item_t   emit_item;
  logic        block_full;
  logic [7:0]  pad_full;
  logic        crc_fb;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign can_load   = !result_valid || result_ready;
  assign trl_state  = crc_mode ? ST_TRL_HI : ST_TRL_LO;
  assign block_full = (fill_count >= 8'(BLOCK_BYTES - 1));
  assign pad_full   = 8'(BLOCK_BYTES) - fill_count;
  assign crc_fb     = check_acc[15] ^ shift_byte[7];

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_item  = '{out_byte: 8'h00, repeat_count: 7'd1, last_result: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item.mode == MODE_EOF) begin
            if (fill_count == 8'd0) begin
              state_next = ST_EOT_A;
            end else if (fill_count < 8'(BLOCK_BYTES)) begin
              state_next = ST_PAD;
            end else begin
              state_next = trl_state;
            end
          end else if (fill_count == 8'd0) begin
            state_next = ST_HDR_SOH;
          end else begin
            state_next = ST_ABSORB;
          end
        end
      end
      ST_HDR_SOH: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_item.out_byte = SYM_SOH;
          state_next         = ST_HDR_NUM;
        end
      end
      ST_HDR_NUM: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_item.out_byte = block_number;
          state_next         = ST_HDR_CPL;
        end
      end
      ST_HDR_CPL: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_item.out_byte = ~block_number;
          state_next         = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (bit_cnt == 3'd7) begin
          if (!is_eof) begin
            state_next = ST_DATA;
          end else if (pad_left == 7'd1) begin
            state_next = trl_state;
          end
        end
      end
      ST_DATA: begin
        if (can_load) begin
          emit                  = 1'b1;
          emit_item.out_byte    = cur_byte;
          emit_item.last_result = !block_full;
          state_next            = block_full ? trl_state : ST_IDLE;
        end
      end
      ST_PAD: begin
        if (can_load) begin
          emit                   = 1'b1;
          emit_item.out_byte     = SYM_PAD;
          emit_item.repeat_count = pad_full[6:0];
          state_next             = ST_ABSORB;
        end
      end
      ST_TRL_HI: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_item.out_byte = check_acc[15:8];
          state_next         = ST_TRL_LO;
        end
      end
      ST_TRL_LO: begin
        if (can_load) begin
          emit                  = 1'b1;
          emit_item.out_byte    = check_acc[7:0];
          emit_item.last_result = !is_eof;
          state_next            = is_eof ? ST_EOT_A : ST_IDLE;
        end
      end
      ST_EOT_A: begin
        if (can_load) begin
          emit               = 1'b1;
          emit_item.out_byte = SYM_EOT;
          state_next         = ST_EOT_B;
        end
      end
      ST_EOT_B: begin
        if (can_load) begin
          emit                  = 1'b1;
          emit_item.out_byte    = SYM_EOT;
          emit_item.last_result = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_item;
    end
    if (accept) begin
      is_eof     <= item.mode;
      cur_byte   <= item.data_byte;
      shift_byte <= item.data_byte;
    end
    if (state == ST_ABSORB) begin
      if (bit_cnt == 3'd7 && is_eof) begin
        pad_left   <= pad_left - 7'd1;
        shift_byte <= SYM_PAD;
      end else begin
        shift_byte <= {shift_byte[6:0], 1'b0};
      end
    end
    if (state == ST_PAD && emit) begin
      pad_left   <= pad_full[6:0];
      shift_byte <= SYM_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      crc_mode     <= 1'b0;
      block_number <= 8'd1;
      fill_count   <= 8'd0;
      check_acc    <= 16'd0;
      bit_cnt      <= 3'd0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        crc_mode <= cfg_wdata;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        bit_cnt <= 3'd0;
        if (item.mode == MODE_DATA && fill_count == 8'd0) begin
          check_acc <= 16'd0;
        end
      end
      if (state == ST_ABSORB) begin
        bit_cnt <= bit_cnt + 3'd1;
        if (crc_mode) begin
          check_acc <= {check_acc[14:0], 1'b0} ^ (crc_fb ? CRC_POLY : 16'h0000);
        end else if (bit_cnt == 3'd0) begin
          check_acc <= {8'h00, check_acc[7:0] + shift_byte};
        end
      end
      if (state == ST_PAD && emit) begin
        bit_cnt <= 3'd0;
      end
      if (state == ST_DATA && emit) begin
        fill_count <= fill_count + 8'd1;
      end
      if (state == ST_TRL_LO && emit && !is_eof) begin
        block_number <= block_number + 8'd1;
        fill_count   <= 8'd0;
        check_acc    <= 16'd0;
      end
      if (state == ST_EOT_B && emit) begin
        block_number <= 8'd1;
        fill_count   <= 8'd0;
        check_acc    <= 16'd0;
      end
    end
  end

endmodule

/* src/xbf_checker.sv */
// Port-level checker for the XMODEM block framer, bound to the top level.
// It depends on xbf_pkg for the beat types and the pad symbol.
`timescale 1ns / 1ps

module xbf_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_ready,
  input logic               result_valid,
  input logic               result_ready,
  input xbf_pkg::out_item_t result
);
  import xbf_pkg::*;

  // A stalled result beat must hold its value.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result pending after reset");

  // An accepted item closes the input to further items.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input reopened right after accepting an item");

  // Only the padding run repeats a byte, and it is never empty.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.repeat_count != 7'd0 &&
      (result.repeat_count == 7'd1 || result.out_byte == SYM_PAD))
    else $error("bad repeat count on result beat");

endmodule

bind xmodem_block_framer_top xbf_checker u_xbf_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

/* tb/testbench.sv */
// Self-checking testbench for the XMODEM block framer: directed and random files, both trailers.
// It depends on xbf_pkg and xmodem_block_framer_top, and keeps its own copy of the framing state.
`timescale 1ns / 1ps

module testbench;
  import xbf_pkg::*;

  localparam int SETTLE_CYCLES = 40;

  logic      clk;
  logic      rst = 1'b1;
  logic      cfg_wen = 1'b0;
  logic      cfg_wdata = 1'b0;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  tx_item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t rx_result;

  out_item_t   expected_beats[$];
  logic        crc_on = 1'b0;
  logic [7:0]  blk_num = 8'd1;
  logic [7:0]  fill_cnt = 8'd0;
  logic [15:0] acc = 16'd0;

  int  err_count = 0;
  int  items_sent = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;

  xmodem_block_framer_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(tx_item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(rx_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [15:0] fold_byte(logic [15:0] sum, logic [7:0] b, logic use_crc);
    logic [15:0] c;
    int k;
    if (use_crc) begin
      c = sum ^ {b, 8'h00};
      for (k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end else begin
      c = {8'h00, sum[7:0] + b};
    end
    return c;
  endfunction

  task automatic push_beat(input logic [7:0] b, input logic [6:0] reps);
    out_item_t beat;
    beat.out_byte = b;
    beat.repeat_count = reps;
    beat.last_result = 1'b0;
    expected_beats.push_back(beat);
  endtask

  task automatic push_trailer();
    if (crc_on) begin
      push_beat(acc[15:8], 7'd1);
      push_beat(acc[7:0], 7'd1);
    end else begin
      push_beat(acc[7:0], 7'd1);
    end
  endtask

  task automatic frame_item(input in_item_t it);
    int pad;
    if (it.mode == MODE_DATA) begin
      if (fill_cnt == 8'd0) begin
        push_beat(SYM_SOH, 7'd1);
        push_beat(blk_num, 7'd1);
        push_beat(8'hFF - blk_num, 7'd1);
        acc = 16'd0;
      end
      push_beat(it.data_byte, 7'd1);
      acc = fold_byte(acc, it.data_byte, crc_on);
      fill_cnt = fill_cnt + 8'd1;
      if (fill_cnt >= BLOCK_BYTES) begin
        push_trailer();
        blk_num = blk_num + 8'd1;
        fill_cnt = 8'd0;
        acc = 16'd0;
      end
    end else begin
      if (fill_cnt != 8'd0) begin
        if (fill_cnt < BLOCK_BYTES) begin
          pad = BLOCK_BYTES - fill_cnt;
          push_beat(SYM_PAD, 7'(pad));
          repeat (pad) acc = fold_byte(acc, SYM_PAD, crc_on);
        end
        push_trailer();
      end
      push_beat(SYM_EOT, 7'd1);
      push_beat(SYM_EOT, 7'd1);
      blk_num = 8'd1;
      fill_cnt = 8'd0;
      acc = 16'd0;
    end
    expected_beats[$].last_result = 1'b1;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t ns: beat with nothing expected, expected none, got %h", $time, rx_result);
        err_count++;
      end else begin
        want = expected_beats.pop_front();
        check_field("out_byte", want.out_byte, rx_result.out_byte);
        check_field("repeat_count", 8'(want.repeat_count), 8'(rx_result.repeat_count));
        check_field("last_result", 8'(want.last_result), 8'(rx_result.last_result));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      result_ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic m, input logic [7:0] d);
    in_item_t beat;
    beat.mode = m;
    beat.data_byte = d;
    if (!calm && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item_valid <= 1'b1;
    tx_item <= beat;
    do @(posedge clk); while (!item_ready);
    frame_item(beat);
    items_sent++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_crc(input logic use_crc);
    cfg_wen <= 1'b1;
    cfg_wdata <= use_crc;
    @(posedge clk);
    cfg_wen <= 1'b0;
    crc_on = use_crc;
  endtask

  // An empty file gives only the two EOT bytes; a single byte gives the longest padding run.
  task automatic test_empty_and_longest_pad();
    send_item(MODE_EOF, 8'hFF);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_EOF, 8'h00);
    wait_idle();
  endtask

  task automatic test_checksum_extremes();
    set_crc(1'b0);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h80);
    send_item(MODE_DATA, 8'h7F);
    send_item(MODE_DATA, 8'h55);
    send_item(MODE_DATA, 8'hAA);
    send_item(MODE_EOF, 8'h5A);
    wait_idle();
  endtask

  task automatic test_crc_extremes();
    set_crc(1'b1);
    send_item(MODE_DATA, 8'hFF);
    send_item(MODE_DATA, 8'h00);
    send_item(MODE_DATA, 8'h01);
    send_item(MODE_DATA, 8'hFE);
    send_item(MODE_DATA, SYM_PAD);
    send_item(MODE_EOF, 8'hA5);
    wait_idle();
  endtask

  // Switching the trailer kind in the middle of a block leaves the accumulator as it is.
  task automatic test_mode_switch_in_block();
    set_crc(1'b1);
    send_item(MODE_DATA, 8'h31);
    send_item(MODE_DATA, 8'h32);
    send_item(MODE_DATA, 8'h33);
    wait_idle();
    set_crc(1'b0);
    send_item(MODE_DATA, 8'hC0);
    send_item(MODE_DATA, 8'h0C);
    wait_idle();
    set_crc(1'b1);
    send_item(MODE_EOF, 8'h00);
    wait_idle();
  endtask

  // The receiver stalls for a long time as a full block starts to go in, so the framer backs up.
  // The end of file then falls right on the block boundary.
  task automatic test_full_block_under_hold();
    int i;
    set_crc(1'($urandom_range(0, 1)));
    hold_left = 400;
    for (i = 0; i < BLOCK_BYTES; i++) begin
      send_item(MODE_DATA, 8'($urandom_range(0, 255)));
    end
    send_item(MODE_EOF, 8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic test_random_files(input int stop_at);
    int len;
    int cut;
    int i;
    while (items_sent < stop_at) begin
      set_crc(1'($urandom_range(0, 1)));
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      cut = -1;
      if (len > 1 && $urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, len - 1);
      end
      for (i = 0; i < len; i++) begin
        if (i == cut) begin
          wait_idle();
          set_crc(1'($urandom_range(0, 1)));
        end
        send_item(MODE_DATA, 8'($urandom_range(0, 255)));
      end
      send_item(MODE_EOF, 8'($urandom_range(0, 255)));
      wait_idle();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_and_longest_pad();
    test_checksum_extremes();
    test_crc_extremes();
    test_mode_switch_in_block();
    test_full_block_under_hold();
    test_random_files(190);
    calm = 1'b1;
    test_random_files(items_sent + 30);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
